// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hw/rtl/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;
    localparam int unsigned FracBitsDefault = 16;
    localparam int unsigned DivStages = 32;
    localparam int unsigned PipeDepth = DivStages + 3;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_CONJ = 3'd3,
        OP_NORM = 3'd4,
        OP_DIV  = 3'd5
    } t_op;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DBZ = 2'd2;

    // per-stage divider data
    typedef struct packed {
        logic          valid;
        logic          is_div;
        logic          dbz;
        logic          neg_re;
        logic          neg_im;
        logic [127:0]  rem_re;
        logic [127:0]  rem_im;
        logic [63:0]   quo_re;
        logic [63:0]   quo_im;
        logic [63:0]   den;
        logic [63:0]   mag_re;
        logic [63:0]   mag_im;
        logic          ovf_re;
        logic          ovf_im;
    } t_cell;

    function automatic logic [31:0] sat_pack(input logic neg, input logic [63:0] mag,
                                             output logic sat);
        sat = 1'b0;
        if (!neg) begin
            if (mag > 64'h7FFF_FFFF) begin
                sat = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return mag[31:0];
        end
        if (mag > 64'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return 32'(-mag[31:0]);
    endfunction
endpackage

// ----- hw/rtl/cau_div_cell.sv -----
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring-division step for both quotient parts; passes the item on.
// ----------------------------------------------------------------------------
module cau_div_cell import cau_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cell i_cell,
    output t_cell o_cell
);
    t_cell r_cell;
    t_cell n_cell;
    logic [64:0] w_tr;
    logic [64:0] w_ti;

    always_comb begin
        n_cell = i_cell;
        w_tr = {i_cell.rem_re[127:64], i_cell.rem_re[63]};
        w_ti = {i_cell.rem_im[127:64], i_cell.rem_im[63]};
        if (i_cell.is_div) begin
            // partial remainder not below divisor: quotient needs more than 32 bits
            n_cell.ovf_re = i_cell.ovf_re || (i_cell.rem_re[127:64] >= i_cell.den);
            n_cell.ovf_im = i_cell.ovf_im || (i_cell.rem_im[127:64] >= i_cell.den);
            n_cell.quo_re = {i_cell.quo_re[62:0], 1'b0};
            n_cell.quo_im = {i_cell.quo_im[62:0], 1'b0};
            n_cell.rem_re = {i_cell.rem_re[126:0], 1'b0};
            n_cell.rem_im = {i_cell.rem_im[126:0], 1'b0};
            if (w_tr >= {1'b0, i_cell.den}) begin
                n_cell.rem_re[127:64] = 64'(w_tr - {1'b0, i_cell.den});
                n_cell.quo_re[0] = 1'b1;
            end else begin
                n_cell.rem_re[127:64] = w_tr[63:0];
            end
            if (w_ti >= {1'b0, i_cell.den}) begin
                n_cell.rem_im[127:64] = 64'(w_ti - {1'b0, i_cell.den});
                n_cell.quo_im[0] = 1'b1;
            end else begin
                n_cell.rem_im[127:64] = w_ti[63:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;
endmodule

// ----- hw/rtl/complex_arith_unit_top.sv -----
// Pipeline: 35 register stages, for every operation. Throughput: one transfer per
// cycle while the output is not stalled.
// A row of 32 division cells sets the depth. The output register holds a result
// while i_stall is high; the whole row then holds, so o_stall is i_stall and o_valid.
// Reset: synchronous active low, clears all valid bits.
// ----------------------------------------------------------------------------
// complex_arith_unit_top
// Q-format complex add, sub, mul, conj, norm and divide.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module complex_arith_unit_top import cau_pkg::*; #(
    parameter int unsigned FRAC_BITS = FracBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_req_type,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_res_re,
    output logic signed [31:0] o_res_im,
    output logic [1:0]  o_status
);
    logic w_en;
    assign w_en = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // stage 1: products, and sums or differences for add, sub and conj
    logic               r1_v;
    logic [2:0]         r1_op;
    logic signed [63:0] r1_p0, r1_p1, r1_p2, r1_p3, r1_d0, r1_d1;
    logic signed [32:0] r1_s_re, r1_s_im;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_op <= i_req_type;
            r1_p0 <= 64'(i_a_re) * 64'(i_b_re);
            r1_p1 <= 64'(i_a_im) * 64'(i_b_im);
            r1_p2 <= 64'(i_a_re) *
                     ((i_req_type == OP_NORM) ? 64'(i_a_re) : 64'(i_b_im));
            r1_p3 <= 64'(i_a_im) *
                     ((i_req_type == OP_NORM) ? 64'(i_a_im) : 64'(i_b_re));
            r1_d0 <= 64'(i_b_re) * 64'(i_b_re);
            r1_d1 <= 64'(i_b_im) * 64'(i_b_im);
            unique case (i_req_type)
                OP_SUB: begin
                    r1_s_re <= 33'(i_a_re) - 33'(i_b_re);
                    r1_s_im <= 33'(i_a_im) - 33'(i_b_im);
                end
                OP_CONJ: begin
                    r1_s_re <= 33'(i_a_re);
                    r1_s_im <= -33'(i_a_im);
                end
                default: begin
                    r1_s_re <= 33'(i_a_re) + 33'(i_b_re);
                    r1_s_im <= 33'(i_a_im) + 33'(i_b_im);
                end
            endcase
        end
    end

    // stage 2: sums, signs and magnitudes (65-bit signed)
    t_cell w_c0;
    logic signed [64:0] w_re, w_im, w_den;
    always_comb begin
        w_re = '0;
        w_im = '0;
        w_den = 65'(r1_d0) + 65'(r1_d1);
        case (r1_op)
            OP_MUL: begin
                w_re = 65'(r1_p0) - 65'(r1_p1);
                w_im = 65'(r1_p2) + 65'(r1_p3);
            end
            OP_NORM: w_re = 65'(r1_p2) + 65'(r1_p3);
            OP_DIV: begin
                w_re = 65'(r1_p0) + 65'(r1_p1);
                w_im = 65'(r1_p3) - 65'(r1_p2);
            end
            default: begin
                w_re = 65'(r1_s_re);
                w_im = 65'(r1_s_im);
            end
        endcase
    end
    logic [64:0] w_mre, w_mim;
    assign w_mre = w_re[64] ? 65'(-w_re) : w_re;
    assign w_mim = w_im[64] ? 65'(-w_im) : w_im;

    t_cell r2;
    always_comb begin
        w_c0 = '0;
        w_c0.valid = r1_v;
        w_c0.neg_re = w_re[64];
        w_c0.neg_im = w_im[64];
        w_c0.den = w_den[63:0];
        w_c0.is_div = (r1_op == OP_DIV) && (w_den != '0);
        w_c0.dbz = (r1_op == OP_DIV) && (w_den == '0);
        if (r1_op == OP_MUL || r1_op == OP_NORM) begin
            w_c0.mag_re = 64'(w_mre >> FRAC_BITS);
            w_c0.mag_im = 64'(w_mim >> FRAC_BITS);
        end else if (r1_op == OP_ADD || r1_op == OP_SUB || r1_op == OP_CONJ) begin
            w_c0.mag_re = w_mre[63:0];
            w_c0.mag_im = w_mim[63:0];
        end
        // dividend mag * 2^FRAC_BITS placed 32 bits up: upper half is the
        // starting partial remainder, lower half feeds 32 quotient bits
        w_c0.rem_re = {63'b0, w_mre} << (FRAC_BITS + 32);
        w_c0.rem_im = {63'b0, w_mim} << (FRAC_BITS + 32);
        if (!w_c0.is_div) begin
            w_c0.rem_re = '0;
            w_c0.rem_im = '0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2.valid <= 1'b0;
        end else if (w_en) begin
            r2 <= w_c0;
        end
    end

    // division row: 32 steps give the exact quotient below 2^32; a larger
    // quotient sets the overflow flag and saturates
    t_cell w_row [DivStages+1];
    assign w_row[0] = r2;
    for (genvar g = 0; g < DivStages; g++) begin : g_div
        cau_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_cell (w_row[g]),
            .o_cell (w_row[g+1])
        );
    end

    // output stage
    t_cell w_last;
    logic [63:0] w_qre, w_qim;
    logic [31:0] w_ore, w_oim;
    logic w_sre, w_sim;
    logic r_v;
    logic [31:0] r_re, r_im;
    logic [1:0] r_st;
    assign w_last = w_row[DivStages];
    assign w_qre = w_last.is_div ? (w_last.ovf_re ? '1 : w_last.quo_re) : w_last.mag_re;
    assign w_qim = w_last.is_div ? (w_last.ovf_im ? '1 : w_last.quo_im) : w_last.mag_im;
    always_comb begin
        w_ore = sat_pack(w_last.neg_re, w_qre, w_sre);
        w_oim = sat_pack(w_last.neg_im, w_qim, w_sim);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= w_last.valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_last.dbz) begin
                r_re <= '0;
                r_im <= '0;
                r_st <= ST_DBZ;
            end else begin
                r_re <= w_ore;
                r_im <= w_oim;
                r_st <= (w_sre || w_sim) ? ST_SAT : ST_OK;
            end
        end
    end

    assign o_valid = r_v;
    assign o_res_re = r_re;
    assign o_res_im = r_im;
    assign o_status = r_st;

    `AST_IMPL(a_dbz_zero, i_clk, i_rst_n, o_valid && o_status == ST_DBZ, {o_res_re, o_res_im} == '0)
    `AST_NEXT(a_hold, i_clk, i_rst_n, o_stall, o_valid && $stable({o_res_re, o_res_im, o_status}))
    `AST_IMPL(a_stall_map, i_clk, i_rst_n, o_stall, o_valid && i_stall)
endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the complex arithmetic unit: each transfer's result is predicted from
// exact wide arithmetic and compared field by field, in order, under idling and stalls.
// ----------------------------------------------------------------------------
module tb_top import cau_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = int'(FracBitsDefault);
    localparam logic [2:0] OP_RSV6 = 3'd6;
    localparam logic [2:0] OP_RSV7 = 3'd7;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic [1:0]  st;
    } t_cplx_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_req_type;
    logic signed [31:0] i_a_re, i_a_im, i_b_re, i_b_im;
    logic        o_valid;
    logic        i_stall;
    logic signed [31:0] o_res_re, o_res_im;
    logic [1:0]  o_status;

    t_cplx_res pending_q[$];
    int  n_errors;
    int  send_idle_pct;
    int  recv_stall_pct;

    complex_arith_unit_top uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [31:0] clamp32(input logic signed [129:0] v, inout logic sat);
        if (v > 130'sh7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -130'sh8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // truncation toward zero of v / 2^FRAC
    function automatic logic signed [129:0] trunc_shift(input logic signed [129:0] v);
        logic signed [129:0] m;
        m = (v < 0) ? -v : v;
        m = m >>> FRAC;
        return (v < 0) ? -m : m;
    endfunction

    function automatic logic signed [129:0] div_trunc(input logic signed [129:0] n,
                                                      input logic signed [129:0] d);
        logic signed [129:0] m, q;
        m = (n < 0) ? -n : n;
        q = (m <<< FRAC) / d;
        if (q > (130'sd1 <<< 40)) q = 130'sd1 <<< 40;
        return (n < 0) ? -q : q;
    endfunction

    function automatic t_cplx_res predict_cplx(input logic [2:0] op,
            input logic signed [31:0] ar, ai, br, bi);
        t_cplx_res r;
        logic sat;
        logic signed [129:0] xr, xi, yr, yi, d;
        xr = ar; xi = ai; yr = br; yi = bi;
        sat = 1'b0;
        r.re = '0; r.im = '0; r.st = ST_OK;
        case (op)
            OP_ADD: begin
                r.re = clamp32(xr + yr, sat);
                r.im = clamp32(xi + yi, sat);
            end
            OP_SUB: begin
                r.re = clamp32(xr - yr, sat);
                r.im = clamp32(xi - yi, sat);
            end
            OP_MUL: begin
                r.re = clamp32(trunc_shift(xr * yr - xi * yi), sat);
                r.im = clamp32(trunc_shift(xr * yi + xi * yr), sat);
            end
            OP_CONJ: begin
                r.re = clamp32(xr, sat);
                r.im = clamp32(-xi, sat);
            end
            OP_NORM: begin
                r.re = clamp32(trunc_shift(xr * xr + xi * xi), sat);
            end
            OP_DIV: begin
                d = yr * yr + yi * yi;
                if (d == 0) begin
                    r.st = ST_DBZ;
                end else begin
                    r.re = clamp32(div_trunc(xr * yr + xi * yi, d), sat);
                    r.im = clamp32(div_trunc(xi * yr - xr * yi, d), sat);
                end
            end
            default: ;
        endcase
        if (r.st == ST_OK && sat) r.st = ST_SAT;
        return r;
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [31:0] ar, ai, br, bi);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= op;
        i_a_re <= ar; i_a_im <= ai; i_b_re <= br; i_b_im <= bi;
        pending_q.push_back(predict_cplx(op, ar, ai, br, bi));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stall driver
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_cplx_res e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %h %h %0d",
                                             o_res_re, o_res_im, o_status);
            end else begin
                e = pending_q.pop_front();
                if (o_res_re !== e.re || o_res_im !== e.im || o_status !== e.st) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp %h %h %0d got %h %h %0d",
                                 e.re, e.im, e.st, o_res_re, o_res_im, o_status);
                end
            end
        end
    end

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return 32'h8000_0000 | $urandom_range(3);
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return $urandom_range(32'h3_0000) - 32'h1_8000;
            3: return 32'($signed($urandom) >>> $urandom_range(24));
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_item(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF);
        send_item(OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
        send_item(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF);
        send_item(OP_SUB, 32'h0005_8000, 32'h0, 32'h0001_0000, 32'h0);
        send_item(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0004_0000);
        send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_8000, 32'h0);
        send_item(OP_CONJ, 32'h1234_5678, 32'h8000_0000, 32'h0, 32'h0);
        send_item(OP_CONJ, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1);
        send_item(OP_NORM, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
        send_item(OP_NORM, 32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0);
        send_item(OP_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        send_item(OP_DIV, 32'h0006_0000, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000);
        send_item(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1);
        send_item(OP_DIV, 32'h0000_0001, 32'h0, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_DIV, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0);
        send_item(OP_DIV, 32'h8000_0000, 32'h0, 32'hFFFF_0000, 32'h0);
        send_item(OP_RSV6, 32'h1, 32'h2, 32'h3, 32'h4);
        send_item(OP_RSV7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_random(input int n, input int idle_pct, input int stall_pct);
        logic [31:0] br, bi;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) begin
            br = rand_operand();
            bi = rand_operand();
            if ($urandom_range(19) == 0) begin
                br = '0;
                bi = '0;
            end
            send_item(3'($urandom_range(7)), rand_operand(), rand_operand(), br, bi);
        end
    endtask

    initial begin
        int guard;
        n_errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_req_type = '0;
        i_a_re = '0; i_a_im = '0; i_b_re = '0; i_b_im = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(200, 0, 0);
        test_random(200, 76, 0);
        test_random(200, 0, 76);
        test_random(200, 25, 25);
        test_random(50, 0, 0);
        i_valid <= 1'b0;
        guard = 0;
        while (pending_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (PipeDepth + 10) @(posedge i_clk);
        if (n_errors == 0 && pending_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
